[rtl/core/ssim_msw_pkg.sv]
// Shared types, widths and constants of the SSIM sliding-window block.
package ssim_msw_pkg;

    // Fixed widths that follow from the field ranges and a window of up to 31.
    localparam int DIM_W  = 13;   // effective image dimension, up to 2047
    localparam int WIN_W  = 5;    // window side
    localparam int SA_W   = 18;   // sum of up to 961 pixels
    localparam int SAA_W  = 26;   // sum of up to 961 squared pixels
    localparam int MW     = 52;   // serial multiplier operand width
    localparam int PW     = 104;  // serial multiplier product width
    localparam int QW     = 17;   // quotient bits of the Q16 ratio and the mean
    localparam int DVW    = PW + QW - 1;  // divider remainder width
    localparam int TOT_W  = 40;   // signed running sum of window values
    localparam int CNT_W  = 21;   // window count
    localparam int MEAN_W = 18;   // signed Q16 mean
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd2;

    // Stabilizing constants scaled by 10000, and the scale factors.
    localparam logic [MW-1:0] K_C1     = MW'(65025);
    localparam logic [MW-1:0] K_C2     = MW'(585225);
    localparam logic [MW-1:0] K_TWO    = MW'(20000);
    localparam logic [MW-1:0] K_ONE    = MW'(10000);
    localparam logic [QW-1:0] Q_ONE    = QW'(65536);

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_DRAIN,
        S_MUL_GO,
        S_MUL_WAIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_TOTAL,
        S_MEAN_GO,
        S_MEAN_WAIT,
        S_OUT
    } state_t;

    // Steps of the window arithmetic, each one pass of the serial multiplier.
    typedef enum logic [3:0] {
        OP_AB,
        OP_M2,
        OP_MSAB,
        OP_MSAA,
        OP_MSBB,
        OP_SA2,
        OP_SB2,
        OP_P2,
        OP_P3,
        OP_N1,
        OP_N2,
        OP_D1,
        OP_D2,
        OP_NUM,
        OP_DEN
    } op_t;

endpackage

[rtl/core/ssim_mean_sliding_window_top.sv]
// Top level: raster pixel intake, window sums from the row store, SSIM math and mean.
// A pixel that completes no window leaves the controller idle, ready for the next pixel. A pixel
// that completes a window takes the row store reads of the window, 15 serial multiplies, each
// as long as set by the multiplier operand's bit length, and one division.
// The last pixel of a frame adds the mean division.
// Reset sets 64 x 64 with window 7 and clears positions and frame totals; row store is not cleared.
module ssim_mean_sliding_window_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_WIN    = 15
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  pixel_a,
    input  logic [7:0]  pixel_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic signed [17:0] ssim_mean,
    output logic        status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import ssim_msw_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_WIN;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);

    // Configuration registers.
    logic [CFG_DAT_W-1:0] cfg_w_reg;
    logic [CFG_DAT_W-1:0] cfg_h_reg;
    logic [WIN_W-1:0]     cfg_win_reg;

    // Geometry.
    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [DIM_W-1:0] dim_min;
    logic [DIM_W-1:0] k_sel;
    logic [WIN_W-1:0] win;
    logic             geo_ok;
    logic [9:0]       m_val;

    // Raster position and row store addressing.
    logic [CW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;
    logic [WIN_W-1:0] slot_reg;
    logic [AW-1:0]    wbase_reg;
    logic [CW-1:0]    colw_reg;
    logic             frame_end_reg;
    logic [DIM_W-1:0] col_p1;
    logic [DIM_W-1:0] row_p1;
    logic             row_done;
    logic             frame_done;
    logic             win_hit;

    // Window read loop.
    logic [WIN_W-1:0] rcol_reg;
    logic [WIN_W-1:0] rslot_reg;
    logic [AW-1:0]    rbase_reg;
    logic             rd_pend_reg;
    logic             last_issue;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic [15:0]      rd_data;
    logic [7:0]       px_a;
    logic [7:0]       px_b;

    // Window sums.
    logic [SA_W-1:0]  sa_reg;
    logic [SA_W-1:0]  sb_reg;
    logic [SAA_W-1:0] saa_reg;
    logic [SAA_W-1:0] sbb_reg;
    logic [SAA_W-1:0] sab_reg;

    // Window arithmetic.
    op_t              op_reg;
    logic [MW-1:0]    ab_reg;
    logic [MW-1:0]    m2_reg;
    logic [MW-1:0]    msab_reg;
    logic [MW-1:0]    msaa_reg;
    logic [MW-1:0]    msbb_reg;
    logic [MW-1:0]    sa2_reg;
    logic [MW-1:0]    sb2_reg;
    logic [MW-1:0]    p2_reg;
    logic [MW-1:0]    p3_reg;
    logic [MW-1:0]    n1_reg;
    logic [MW-1:0]    n2mag_reg;
    logic             n2neg_reg;
    logic [MW-1:0]    d1_reg;
    logic [MW-1:0]    d2_reg;
    logic [PW-1:0]    num_reg;
    logic [PW-1:0]    den_reg;
    logic             cv_neg;
    logic [MW-1:0]    cv_mag;
    logic signed [MW:0] n2_sum;
    logic [MW-1:0]    mul_a;
    logic [MW-1:0]    mul_b;
    logic [MW-1:0]    prod_lo;
    logic             mul_start;
    logic             mul_busy;
    logic [PW-1:0]    mul_prod;

    // Divider and frame accumulation.
    logic             div_start;
    logic             div_busy;
    logic [DVW-1:0]   div_dividend;
    logic [PW-1:0]    div_divisor;
    logic [QW-1:0]    div_q;
    logic signed [TOT_W-1:0] total_reg;
    logic [TOT_W-1:0] total_mag;
    logic [CNT_W-1:0] count_reg;
    logic signed [QW:0] win_val;
    logic             mean_ok;

    // Result register.
    logic                     out_valid_reg;
    logic signed [MEAN_W-1:0] ssim_mean_reg;
    logic                     status_reg;
    logic                     out_load;

    state_t state_reg;
    state_t state_next;
    logic   in_fire;
    logic   cfg_fire;
    logic   st_wr_en;
    logic   st_rd_en;

    assign in_fire  = in_valid && in_ready;
    assign cfg_fire = cfg_valid && cfg_ready;

    // Effective dimensions and window side.
    always_comb
    begin
        if (cfg_w_reg == '0)
            w_eff = DIM_W'(1);
        else if (DIM_W'(cfg_w_reg) > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        else
            w_eff = DIM_W'(cfg_w_reg);
        if (cfg_h_reg == '0)
            h_eff = DIM_W'(1);
        else if (DIM_W'(cfg_h_reg) > DIM_W'(MAX_HEIGHT))
            h_eff = DIM_W'(MAX_HEIGHT);
        else
            h_eff = DIM_W'(cfg_h_reg);
        dim_min = (w_eff < h_eff) ? w_eff : h_eff;
        k_sel = (cfg_win_reg < WIN_W'(3)) ? DIM_W'(3) : DIM_W'(cfg_win_reg);
        if (k_sel > DIM_W'(MAX_WIN))
            k_sel = DIM_W'(MAX_WIN);
        if (k_sel > dim_min)
            k_sel = dim_min;
        if (!k_sel[0])
            k_sel = k_sel - DIM_W'(1);
        win    = WIN_W'(k_sel);
        geo_ok = k_sel >= DIM_W'(3);
        m_val  = 10'(win) * 10'(win);
    end

    // Raster position tests for the pixel at the input.
    assign col_p1     = DIM_W'(col_reg) + DIM_W'(1);
    assign row_p1     = DIM_W'(row_reg) + DIM_W'(1);
    assign row_done   = col_p1 >= w_eff;
    assign frame_done = row_done && (row_p1 >= h_eff);
    assign win_hit    = geo_ok && (col_p1 >= DIM_W'(win)) && (row_p1 >= DIM_W'(win));

    // Row store addresses.
    assign wr_addr    = wbase_reg + AW'(col_reg);
    assign rd_addr    = rbase_reg + AW'(colw_reg) + AW'(rcol_reg) + AW'(1) - AW'(win);
    assign last_issue = (rcol_reg == win - WIN_W'(1)) && (rslot_reg == win - WIN_W'(1));
    assign px_a       = rd_data[15:8];
    assign px_b       = rd_data[7:0];

    ssim_msw_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (wr_addr),
        .wr_data ({pixel_a, pixel_b}),
        .rd_en   (st_rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Covariance term sign and magnitude.
    assign cv_neg = msab_reg < ab_reg;
    assign cv_mag = cv_neg ? (ab_reg - msab_reg) : (msab_reg - ab_reg);
    assign prod_lo = mul_prod[MW-1:0];
    assign n2_sum = cv_neg ? ($signed({1'b0, p3_reg}) - $signed({1'b0, prod_lo}))
                           : ($signed({1'b0, p3_reg}) + $signed({1'b0, prod_lo}));

    // Multiplier operand selection per arithmetic step.
    always_comb
    begin
        case (op_reg)
            OP_AB:   begin mul_a = MW'(sa_reg);   mul_b = MW'(sb_reg);  end
            OP_M2:   begin mul_a = MW'(m_val);    mul_b = MW'(m_val);   end
            OP_MSAB: begin mul_a = MW'(sab_reg);  mul_b = MW'(m_val);   end
            OP_MSAA: begin mul_a = MW'(saa_reg);  mul_b = MW'(m_val);   end
            OP_MSBB: begin mul_a = MW'(sbb_reg);  mul_b = MW'(m_val);   end
            OP_SA2:  begin mul_a = MW'(sa_reg);   mul_b = MW'(sa_reg);  end
            OP_SB2:  begin mul_a = MW'(sb_reg);   mul_b = MW'(sb_reg);  end
            OP_P2:   begin mul_a = m2_reg;        mul_b = K_C1;         end
            OP_P3:   begin mul_a = m2_reg;        mul_b = K_C2;         end
            OP_N1:   begin mul_a = ab_reg;        mul_b = K_TWO;        end
            OP_N2:   begin mul_a = cv_mag;        mul_b = K_TWO;        end
            OP_D1:   begin mul_a = sa2_reg + sb2_reg; mul_b = K_ONE;    end
            OP_D2:
            begin
                mul_a = (msaa_reg - sa2_reg) + (msbb_reg - sb2_reg);
                mul_b = K_ONE;
            end
            OP_NUM:  begin mul_a = n1_reg;        mul_b = n2mag_reg;    end
            OP_DEN:  begin mul_a = d1_reg;        mul_b = d2_reg;       end
            default: begin mul_a = '0;            mul_b = '0;           end
        endcase
    end

    ssim_msw_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .busy    (mul_busy),
        .product (mul_prod)
    );

    // Divider operands: window ratio or frame mean.
    assign total_mag    = total_reg[TOT_W-1] ? TOT_W'(-total_reg) : TOT_W'(total_reg);
    assign div_dividend = (state_reg == S_MEAN_GO) ? DVW'(total_mag)
                                                   : {num_reg, {(QW-1){1'b0}}};
    assign div_divisor  = (state_reg == S_MEAN_GO) ? PW'(count_reg) : den_reg;

    ssim_msw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign win_val = n2neg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    assign mean_ok = geo_ok && (count_reg != '0);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (win_hit)
                        state_next = S_READ;
                    else if (frame_done)
                        state_next = mean_ok ? S_MEAN_GO : S_OUT;
                end
            end
            S_READ:
            begin
                if (last_issue)
                    state_next = S_DRAIN;
            end
            S_DRAIN:     state_next = S_MUL_GO;
            S_MUL_GO:    state_next = S_MUL_WAIT;
            S_MUL_WAIT:
            begin
                if (!mul_busy)
                    state_next = (op_reg == OP_DEN) ? S_DIV_GO : S_MUL_GO;
            end
            S_DIV_GO:    state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (!div_busy)
                    state_next = S_TOTAL;
            end
            S_TOTAL:     state_next = frame_end_reg ? S_MEAN_GO : S_IDLE;
            S_MEAN_GO:   state_next = S_MEAN_WAIT;
            S_MEAN_WAIT:
            begin
                if (!div_busy)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        in_ready  = state_reg == S_IDLE;
        cfg_ready = state_reg == S_IDLE;
        mul_start = state_reg == S_MUL_GO;
        div_start = (state_reg == S_DIV_GO) || (state_reg == S_MEAN_GO);
        st_rd_en  = state_reg == S_READ;
        st_wr_en  = in_fire && geo_ok;
        out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg   <= CFG_DAT_W'(64);
            cfg_h_reg   <= CFG_DAT_W'(64);
            cfg_win_reg <= WIN_W'(7);
        end
        else if (cfg_fire)
        begin
            case (cfg_index)
                REG_WIDTH:  cfg_w_reg   <= cfg_data;
                REG_HEIGHT: cfg_h_reg   <= cfg_data;
                REG_WINDOW: cfg_win_reg <= cfg_data[WIN_W-1:0];
                default:    ;
            endcase
        end
    end

    // Raster position, frame totals and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            slot_reg      <= '0;
            wbase_reg     <= '0;
            frame_end_reg <= 1'b0;
            total_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            ssim_mean_reg <= '0;
            status_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_fire && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                             cfg_index == REG_WINDOW))
            begin
                col_reg   <= '0;
                row_reg   <= '0;
                slot_reg  <= '0;
                wbase_reg <= '0;
                total_reg <= '0;
                count_reg <= '0;
            end
            else if (in_fire)
            begin
                frame_end_reg <= frame_done;
                if (!row_done)
                begin
                    col_reg <= col_reg + 1'b1;
                end
                else if (frame_done)
                begin
                    col_reg   <= '0;
                    row_reg   <= '0;
                    slot_reg  <= '0;
                    wbase_reg <= '0;
                end
                else
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 1'b1;
                    if (slot_reg + WIN_W'(1) >= win)
                    begin
                        slot_reg  <= '0;
                        wbase_reg <= '0;
                    end
                    else
                    begin
                        slot_reg  <= slot_reg + 1'b1;
                        wbase_reg <= wbase_reg + AW'(MAX_WIDTH);
                    end
                end
            end
            else if (state_reg == S_TOTAL)
            begin
                total_reg <= total_reg + TOT_W'(win_val);
                count_reg <= count_reg + 1'b1;
            end
            else if (out_load)
            begin
                total_reg <= '0;
                count_reg <= '0;
            end

            // Result register is parted from the intake by its own valid bit.
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                if (mean_ok)
                begin
                    ssim_mean_reg <= total_reg[TOT_W-1] ? -$signed({1'b0, div_q})
                                                        : $signed({1'b0, div_q});
                    status_reg    <= 1'b0;
                end
                else
                begin
                    ssim_mean_reg <= '0;
                    status_reg    <= 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Window read loop control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rcol_reg    <= '0;
            rslot_reg   <= '0;
            rbase_reg   <= '0;
            rd_pend_reg <= 1'b0;
            op_reg      <= OP_AB;
        end
        else
        begin
            rd_pend_reg <= state_reg == S_READ;
            if (in_fire)
            begin
                rcol_reg  <= '0;
                rslot_reg <= '0;
                rbase_reg <= '0;
            end
            else if (state_reg == S_READ)
            begin
                if (rcol_reg == win - WIN_W'(1))
                begin
                    rcol_reg  <= '0;
                    rslot_reg <= rslot_reg + 1'b1;
                    rbase_reg <= rbase_reg + AW'(MAX_WIDTH);
                end
                else
                begin
                    rcol_reg <= rcol_reg + 1'b1;
                end
            end
            if (state_reg == S_DRAIN)
                op_reg <= OP_AB;
            else if ((state_reg == S_MUL_WAIT) && !mul_busy && (op_reg != OP_DEN))
                op_reg <= op_t'(op_reg + 1'b1);
        end
    end

    // Window sums and arithmetic results.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            colw_reg <= col_reg;
            sa_reg   <= '0;
            sb_reg   <= '0;
            saa_reg  <= '0;
            sbb_reg  <= '0;
            sab_reg  <= '0;
        end
        else if (rd_pend_reg)
        begin
            sa_reg  <= sa_reg + SA_W'(px_a);
            sb_reg  <= sb_reg + SA_W'(px_b);
            saa_reg <= saa_reg + SAA_W'(px_a * px_a);
            sbb_reg <= sbb_reg + SAA_W'(px_b * px_b);
            sab_reg <= sab_reg + SAA_W'(px_a * px_b);
        end

        if ((state_reg == S_MUL_WAIT) && !mul_busy)
        begin
            case (op_reg)
                OP_AB:   ab_reg   <= prod_lo;
                OP_M2:   m2_reg   <= prod_lo;
                OP_MSAB: msab_reg <= prod_lo;
                OP_MSAA: msaa_reg <= prod_lo;
                OP_MSBB: msbb_reg <= prod_lo;
                OP_SA2:  sa2_reg  <= prod_lo;
                OP_SB2:  sb2_reg  <= prod_lo;
                OP_P2:   p2_reg   <= prod_lo;
                OP_P3:   p3_reg   <= prod_lo;
                OP_N1:   n1_reg   <= prod_lo + p2_reg;
                OP_N2:
                begin
                    n2neg_reg <= n2_sum[MW];
                    n2mag_reg <= n2_sum[MW] ? MW'(-n2_sum) : MW'(n2_sum);
                end
                OP_D1:   d1_reg   <= prod_lo + p2_reg;
                OP_D2:   d2_reg   <= prod_lo + p3_reg;
                OP_NUM:  num_reg  <= mul_prod;
                OP_DEN:  den_reg  <= mul_prod;
                default: ;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign ssim_mean = ssim_mean_reg;
    assign status    = status_reg;

    // The multiplier is never restarted while a product is still forming.
    a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mul_start |-> !mul_busy)
        else $error("multiplier started while busy");

    // A finished division never exceeds one in Q16.
    a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(div_busy) |-> (div_q <= Q_ONE))
        else $error("quotient above one");

    // The frame mean is only divided by a nonzero window count.
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MEAN_GO) |-> (count_reg != '0))
        else $error("mean division with zero count");

    // A pending result is never overwritten before it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !out_ready) |=> (state_reg == S_OUT))
        else $error("result overwritten while pending");

endmodule

[rtl/core/ssim_msw_store.sv]
// Row store: single-port-write, registered-read memory of pixel pairs.
module ssim_msw_store #(
    parameter int DEPTH = 15360,
    parameter int AW    = 14
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/ssim_msw_mul.sv]
// Shift-and-add multiplier that stops once the remaining multiplier bits are zero.
module ssim_msw_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ssim_msw_pkg::MW-1:0] op_a,
    input  logic [ssim_msw_pkg::MW-1:0] op_b,
    output logic                       busy,
    output logic [ssim_msw_pkg::PW-1:0] product
);
    import ssim_msw_pkg::*;

    logic [PW-1:0] acc_reg;
    logic [PW-1:0] a_reg;
    logic [MW-1:0] b_reg;
    logic          busy_reg;

    // Control: busy until the multiplier operand is used up.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
        end
        else if (busy_reg && (b_reg == '0))
        begin
            busy_reg <= 1'b0;
        end
    end

    // Datapath: one multiplier bit per cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= PW'(op_a);
            b_reg   <= op_b;
        end
        else if (busy_reg && (b_reg != '0))
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    assign busy    = busy_reg;
    assign product = acc_reg;

endmodule

[rtl/core/ssim_msw_div.sv]
// Restoring divider giving a quotient of QW bits, one bit per cycle.
module ssim_msw_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ssim_msw_pkg::DVW-1:0] dividend,
    input  logic [ssim_msw_pkg::PW-1:0]  divisor,
    output logic                        busy,
    output logic [ssim_msw_pkg::QW-1:0]  quotient
);
    import ssim_msw_pkg::*;

    localparam int CNT_BITS = $clog2(QW + 1);

    logic [DVW-1:0]      rem_reg;
    logic [DVW-1:0]      ds_reg;
    logic [QW-1:0]       q_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                ge;

    assign ge = rem_reg >= ds_reg;

    // Step counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_BITS'(QW);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Compare against the shifted divisor and subtract where it fits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            ds_reg  <= DVW'(divisor) << (QW - 1);
            q_reg   <= '0;
        end
        else if (cnt_reg != '0)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - ds_reg;
            end
            q_reg  <= {q_reg[QW-2:0], ge};
            ds_reg <= ds_reg >> 1;
        end
    end

    assign busy     = cnt_reg != '0;
    assign quotient = q_reg;

endmodule
